// File: sv/lfsrkw_pkg.sv
// Package: item types, step control struct and keystream functions for the word decryptor.
package lfsrkw_pkg;

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned STATE_W = 32;

    typedef struct packed {
        logic [WORD_W-1:0] cipher_word;
        logic              last_word;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] plain_word;
        logic              last_out;
    } t_out_item;

    typedef struct packed {
        logic advance;
        logic last;
    } t_step;

    function automatic logic [STATE_W-1:0] scramble(input logic [STATE_W-1:0] k);
        logic [STATE_W-1:0] d;
        logic [STATE_W-1:0] t;
        d = (k >> 1) ^ k;
        t = ((k >> 15) & 32'h0000_2000) | (k & 32'h0100_0000);
        t = (t >> 1) | (k & 32'h0002_0000);
        t = (t >> 2) | (k & 32'h0000_1000);
        t = (t >> 3) | (((k >> 7) ^ k) & 32'h0008_0000);
        t = (t >> 1) | (((k >> 15) ^ k) & 32'h0000_4000);
        t = (t >> 2) | (k & 32'h0000_2000);
        t = ((t >> 2) | (d & 32'h0000_0040) | (k & 32'h0000_0020)) >> 1;
        t = t | (((k >> 9) ^ (k << 8)) & 32'h0000_0800);
        t = t | (((k >> 20) ^ (k << 1)) & 32'h0000_0004);
        t = t | (((k << 3) ^ (k >> 16)) & 32'h0000_4000);
        t = t | (((k >> 2) ^ (k >> 16)) & 32'h0000_0080);
        t = t | (((k << 6) ^ (k >> 7)) & 32'h0000_0100);
        t = t | ((k & 32'h0000_0100) << 7);
        return t;
    endfunction

    function automatic logic [WORD_W-1:0] keystream(input logic [STATE_W-1:0] k);
        logic [STATE_W-1:0] s;
        logic [WORD_W-1:0]  hi;
        logic [WORD_W-1:0]  lo;
        s  = scramble(k);
        hi = s[23:8];
        lo = {s[7:1], s[0] | k[0], 8'h00};
        return hi + lo;
    endfunction

    function automatic logic feedback(input logic [STATE_W-1:0] k);
        return k[0] ^ k[10] ^ k[30] ^ k[31];
    endfunction

endpackage

// File: sv/lfsrkw_state.sv
// Key seed register and 32-bit shift register with reload after the last word.
module lfsrkw_state
    import lfsrkw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [STATE_W-1:0] i_cfg_wdata,
    input  t_step              i_step,
    output logic [STATE_W-1:0] o_k
);

    logic [STATE_W-1:0] r_key_seed;
    logic [STATE_W-1:0] r_shift;
    logic               r_reload;
    logic [STATE_W-1:0] n_shift;
    logic               n_reload;

    assign o_k = r_reload ? r_key_seed : r_shift;

    always_comb begin
        n_shift  = r_shift;
        n_reload = r_reload;
        if (i_step.advance) begin
            n_shift  = {feedback(o_k), o_k[STATE_W-1:1]};
            n_reload = i_step.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_seed <= '0;
            r_shift    <= '0;
            r_reload   <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_key_seed <= i_cfg_wdata;
            end
            r_shift  <= n_shift;
            r_reload <= n_reload;
        end
    end

endmodule

// File: sv/lfsrkw_xor.sv
// Keystream derivation and ciphertext XOR for one staged item.
module lfsrkw_xor
    import lfsrkw_pkg::*;
(
    input  t_in_item           i_item,
    input  logic [STATE_W-1:0] i_k,
    output t_out_item          o_item
);

    assign o_item.plain_word = i_item.cipher_word ^ keystream(i_k);
    assign o_item.last_out   = i_item.last_word;

endmodule

// File: sv/lfsr_keystream_word_decryptor_unit.sv
// Top level: two-register stream decryptor for 16-bit words.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+------------------------
//  in       | input     | i_in_valid / o_in_ready      | i_in_item  (t_in_item)
//  out      | output    | o_out_valid / i_out_ready    | o_out_item (t_out_item)
//  config   | input     | i_cfg_we (no wait)           | i_cfg_wdata (key seed)
//
// One item per cycle sustained while the result is not stalled; each accepted item is registered
// in the input stage, then in the result register. The shift register steps at acceptance, so
// its feedback loop sets the rate. Synchronous active-low reset empties both
// stages and arms a reload from the key seed. A stalled result holds the output
// register and the input stage; the input side keeps accepting while either stage has room.
module lfsr_keystream_word_decryptor_unit
    import lfsrkw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    input  logic               i_cfg_we,
    input  logic [STATE_W-1:0] i_cfg_wdata
);

    logic               r_s1_valid;
    t_in_item           r_s1_item;
    logic [STATE_W-1:0] r_s1_k;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               in_acc;
    logic               s2_room;
    logic               s1_move;
    logic [STATE_W-1:0] k_now;
    t_step              step;
    t_out_item          xor_item;

    assign s2_room    = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && s2_room;
    assign o_in_ready = !r_s1_valid || s2_room;
    assign in_acc     = i_in_valid && o_in_ready;

    assign step.advance = in_acc;
    assign step.last    = i_in_item.last_word;

    lfsrkw_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .o_k         (k_now)
    );

    lfsrkw_xor u_xor (
        .i_item (r_s1_item),
        .i_k    (r_s1_k),
        .o_item (xor_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= i_in_item;
            r_s1_k    <= k_now;
        end
        if (s1_move) begin
            r_out_item <= xor_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: sv/lfsrkw_checker.sv
// Port-level checker for the word decryptor, bound to the top level.
module lfsrkw_checker
    import lfsrkw_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |-> ##2 o_out_valid)
        else $error("accepted item did not reach the output");

    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled while output side has room");

endmodule

bind lfsr_keystream_word_decryptor_unit lfsrkw_checker u_lfsrkw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
